[hdl/tts_pkg.sv]
// ----------------------------------------------------------------------------
// tts_pkg
// Types, tables and constants shared by the triangle tone sequencer.
// ----------------------------------------------------------------------------
package tts_pkg;

  localparam int unsigned PH_W     = 14;  // phase accumulator, modulo SAMPLE_RATE
  localparam int unsigned FREQ_W   = 11;  // note frequency in Hz
  localparam int unsigned POS_W    = 12;  // position within a note, in samples
  localparam int unsigned ENV_W    = 7;   // envelope, 0 to 64
  localparam int unsigned AMP_W    = 12;  // voice amplitude
  localparam int unsigned MAG_W    = 13;  // triangle magnitude, 0 to 8000
  localparam int unsigned SAMPLE_W = 14;
  localparam int unsigned OPND_W   = 20;  // shared multiplier operand width
  localparam int unsigned PROD_W   = 2 * OPND_W;
  localparam int unsigned MULR_W   = 39;  // holds the widest product actually produced

  localparam int unsigned SAMPLE_RATE = 16000;
  localparam int unsigned HALF_RATE   = 8000;
  localparam int unsigned TRI_TOP     = 24000;
  localparam int unsigned ENV_LEN     = 64;
  localparam int unsigned STEP_LEN    = 3200;
  localparam int unsigned MELODY_LEN  = 2700;
  localparam int unsigned BASS_LEN    = 1600;
  localparam int unsigned MELODY_AMP  = 1540;
  localparam int unsigned BASS_AMP    = 770;
  localparam int unsigned CUE_AMP     = 2600;

  // x / 8000 = (x >> 6) / 125; the quotient by 125 is (y * REC_K) >> REC_SH,
  // exact for y below about six million
  localparam int unsigned ENV_SH = 6;
  localparam int unsigned REC_SH = 26;
  localparam int unsigned REC_K  = 536871;

  typedef struct packed {
    logic       mode;
    logic       enable;
    logic       music_on;
    logic [2:0] cue;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       running;
  } out_item_t;

  typedef enum logic [2:0] {
    DP_IDLE,
    DP_CLEAR,
    DP_LOAD,
    DP_MUL_AMP,
    DP_MUL_REC,
    DP_MUL_ENV
  } dp_op_t;

  typedef struct packed {
    dp_op_t           op;
    logic [AMP_W-1:0] amp;
  } dp_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MAMP,
    ST_MREC,
    ST_MENV,
    ST_UPD,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    V_MEL,
    V_BASS,
    V_CUE
  } voice_t;

  typedef enum logic [2:0] {
    CUE_NONE,
    CUE_BUTTON,
    CUE_START,
    CUE_STOP,
    CUE_WIN,
    CUE_LOSE,
    CUE_MATCH,
    CUE_BAD
  } cue_t;

  typedef struct packed {
    logic [FREQ_W-1:0] freq;
    logic [POS_W-1:0]  dur;
  } note_t;

  localparam logic [FREQ_W-1:0] TUNE_TAB [32] = '{
    11'd440, 11'd0,   11'd659, 11'd440, 11'd784, 11'd659, 11'd523, 11'd0,
    11'd587, 11'd0,   11'd698, 11'd587, 11'd880, 11'd784, 11'd659, 11'd0,
    11'd523, 11'd659, 11'd784, 11'd0,   11'd698, 11'd587, 11'd440, 11'd0,
    11'd494, 11'd587, 11'd659, 11'd784, 11'd659, 11'd494, 11'd440, 11'd0
  };

  localparam logic [FREQ_W-1:0] LOW_TAB [4] = '{11'd110, 11'd147, 11'd131, 11'd165};

  localparam logic [FREQ_W-1:0] CUE_FREQ [16] = '{
    11'd1047, 11'd784, 11'd523, 11'd659, 11'd784, 11'd988, 11'd392, 11'd330,
    11'd262,  11'd523, 11'd659, 11'd784, 11'd0,   11'd784, 11'd0,   11'd0
  };

  localparam logic [7:0] CUE_MS [16] = '{
    8'd28,  8'd24, 8'd40, 8'd80, 8'd80, 8'd120, 8'd100, 8'd100,
    8'd120, 8'd90, 8'd90, 8'd90, 8'd60, 8'd90,  8'd0,   8'd0
  };

  localparam logic [3:0] CUE_FIRST [8] = '{4'd0, 4'd0, 4'd1, 4'd2, 4'd3, 4'd6, 4'd9, 4'd0};
  localparam logic [2:0] CUE_COUNT [8] = '{3'd0, 3'd1, 3'd1, 3'd1, 3'd3, 3'd3, 3'd6, 3'd0};

  localparam logic [2:0]        MATCH_LAST      = 3'd5;
  localparam logic [FREQ_W-1:0] MATCH_LAST_FREQ = 11'd1047;
  localparam logic [7:0]        MATCH_LAST_MS   = 8'd220;

  // frequency and length in samples (16 per millisecond) of one cue note
  function automatic note_t cue_tone(input logic [2:0] c, input logic [2:0] idx);
    note_t      n;
    logic [7:0] ms;
    logic [3:0] ti;
    n  = '0;
    ms = '0;
    ti = CUE_FIRST[c] + {1'b0, idx};
    if (idx < CUE_COUNT[c]) begin
      if (c == CUE_MATCH && idx == MATCH_LAST) begin
        n.freq = MATCH_LAST_FREQ;
        ms     = MATCH_LAST_MS;
      end else begin
        n.freq = CUE_FREQ[ti];
        ms     = CUE_MS[ti];
      end
    end
    n.dur = {ms, 4'b0000};
    return n;
  endfunction

endpackage

[hdl/triangle_tone_sequencer.sv]
// ----------------------------------------------------------------------------
// triangle_tone_sequencer
// Three-voice triangle tone generator with melody, bass and cue sequencing.
// ----------------------------------------------------------------------------
// Each tick transfer yields one signed sample at an assumed 16 kHz: the sum of
// a looping 32-step melody voice, a bass voice and a one-shot cue voice, each a
// triangle wave from a phase accumulator with a linear 64-sample attack and
// release. A set transfer clears everything (enable low) or enables the
// generator, sets the music flag and starts or cancels a cue; its result
// carries a zero sample. Every result reports whether the generator is still
// running. All three voices go through one shared datapath with one
// multiplier: a sounding voice passes the load and multiply states, a silent
// one the load state only, and a tick ends with the update and done states;
// a set command or a tick while disabled goes straight to done. The input is
// not ready while an item is in work; a finished result sits in an output
// register, so the next item may be taken while it waits.
// ----------------------------------------------------------------------------
module triangle_tone_sequencer
  import tts_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  state_t state_r, state_nxt;
  voice_t voice_r;

  // generator state
  logic              enabled_r;
  logic              music_r;
  logic [2:0]        cue_r;
  logic [2:0]        cue_idx_r;
  logic [POS_W-1:0]  cue_cnt_r;
  logic [PH_W-1:0]   cue_ph_r;
  logic [POS_W-1:0]  mus_pos_r;
  logic [4:0]        mus_step_r;
  logic [PH_W-1:0]   mel_ph_r;
  logic [PH_W-1:0]   bass_ph_r;

  logic              out_valid_r;
  out_item_t         out_data_r;

  // selected voice
  logic [FREQ_W-1:0] v_freq;
  logic [POS_W-1:0]  v_pos;
  logic [POS_W-1:0]  v_dur;
  logic [AMP_W-1:0]  v_amp;
  logic [PH_W-1:0]   v_phase;
  logic              v_on;
  logic              v_live;
  logic              v_last;

  note_t             cur_note;
  note_t             next_note;
  logic [POS_W-1:0]  cue_cnt_inc;

  logic              in_xfer;
  logic              out_free;
  dp_ctl_t           dp_ctl;
  logic [PH_W-1:0]   dp_phase_new;
  logic signed [SAMPLE_W-1:0] dp_acc;

  assign in_xfer     = in_valid && in_ready;
  assign out_free    = !out_valid_r || out_ready;
  assign cur_note    = cue_tone(cue_r, cue_idx_r);
  assign next_note   = cue_tone(cue_r, cue_idx_r + 3'd1);
  assign cue_cnt_inc = cue_cnt_r + POS_W'(1);

  // route the voice under work to the shared datapath
  always_comb begin
    unique case (voice_r)
      V_MEL: begin
        v_freq  = TUNE_TAB[mus_step_r];
        v_pos   = mus_pos_r;
        v_dur   = POS_W'(MELODY_LEN);
        v_amp   = AMP_W'(MELODY_AMP);
        v_phase = mel_ph_r;
        v_on    = music_r;
      end
      V_BASS: begin
        v_freq  = LOW_TAB[mus_step_r[4:3]];
        v_pos   = mus_pos_r;
        v_dur   = POS_W'(BASS_LEN);
        v_amp   = AMP_W'(BASS_AMP);
        v_phase = bass_ph_r;
        v_on    = music_r;
      end
      V_CUE: begin
        v_freq  = cur_note.freq;
        v_pos   = cue_cnt_r;
        v_dur   = cur_note.dur;
        v_amp   = AMP_W'(CUE_AMP);
        v_phase = cue_ph_r;
        v_on    = cue_r != CUE_NONE;
      end
      default: begin
        v_freq  = '0;
        v_pos   = '0;
        v_dur   = '0;
        v_amp   = '0;
        v_phase = '0;
        v_on    = 1'b0;
      end
    endcase
  end

  // a rest or a finished note stays silent and keeps its phase
  assign v_live = v_on && (v_freq != '0) && (v_pos < v_dur);
  assign v_last = voice_r == V_CUE;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = (!in_data.mode && enabled_r) ? ST_LOAD : ST_DONE;
        end
      end
      ST_LOAD: begin
        if (v_live) begin
          state_nxt = ST_MAMP;
        end else if (v_last) begin
          state_nxt = ST_UPD;
        end
      end
      ST_MAMP: state_nxt = ST_MREC;
      ST_MREC: state_nxt = ST_MENV;
      ST_MENV: state_nxt = v_last ? ST_UPD : ST_LOAD;
      ST_UPD:  state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready   = 1'b0;
    dp_ctl.op  = DP_IDLE;
    dp_ctl.amp = v_amp;
    unique case (state_r)
      ST_IDLE: begin
        in_ready  = 1'b1;
        dp_ctl.op = in_valid ? DP_CLEAR : DP_IDLE;
      end
      ST_LOAD: dp_ctl.op = v_live ? DP_LOAD : DP_IDLE;
      ST_MAMP: dp_ctl.op = DP_MUL_AMP;
      ST_MREC: dp_ctl.op = DP_MUL_REC;
      ST_MENV: dp_ctl.op = DP_MUL_ENV;
      default: dp_ctl.op = DP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // walk the voices in order: melody, bass, cue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      voice_r <= V_MEL;
    end else if (state_r == ST_IDLE) begin
      voice_r <= V_MEL;
    end else if ((state_r == ST_LOAD && !v_live) || state_r == ST_MENV) begin
      unique case (voice_r)
        V_MEL:   voice_r <= V_BASS;
        V_BASS:  voice_r <= V_CUE;
        default: voice_r <= V_CUE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r  <= 1'b0;
      music_r    <= 1'b0;
      cue_r      <= CUE_NONE;
      cue_idx_r  <= '0;
      cue_cnt_r  <= '0;
      cue_ph_r   <= '0;
      mus_pos_r  <= '0;
      mus_step_r <= '0;
      mel_ph_r   <= '0;
      bass_ph_r  <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_xfer && in_data.mode) begin
            if (!in_data.enable) begin
              // clear everything
              enabled_r  <= 1'b0;
              music_r    <= 1'b0;
              cue_r      <= CUE_NONE;
              cue_idx_r  <= '0;
              cue_cnt_r  <= '0;
              cue_ph_r   <= '0;
              mus_pos_r  <= '0;
              mus_step_r <= '0;
              mel_ph_r   <= '0;
              bass_ph_r  <= '0;
            end else begin
              // latch the cue and restart it; music keeps its place
              enabled_r <= 1'b1;
              music_r   <= in_data.music_on;
              cue_r     <= (in_data.cue == CUE_BAD) ? CUE_NONE : in_data.cue;
              cue_idx_r <= '0;
              cue_cnt_r <= '0;
              cue_ph_r  <= '0;
            end
          end
        end
        ST_LOAD: begin
          if (v_live) begin
            unique case (voice_r)
              V_MEL:   mel_ph_r  <= dp_phase_new;
              V_BASS:  bass_ph_r <= dp_phase_new;
              default: cue_ph_r  <= dp_phase_new;
            endcase
          end
        end
        ST_UPD: begin
          // advance the music position, stepping the tune every STEP_LEN samples
          if (music_r) begin
            if (mus_pos_r == POS_W'(STEP_LEN - 1)) begin
              mus_pos_r  <= '0;
              mus_step_r <= mus_step_r + 5'd1;
            end else begin
              mus_pos_r <= mus_pos_r + POS_W'(1);
            end
          end
          // advance the cue; drop it once its last note has elapsed
          if (cue_r != CUE_NONE) begin
            if (cue_cnt_inc >= cur_note.dur) begin
              cue_cnt_r <= '0;
              cue_ph_r  <= '0;
              cue_idx_r <= cue_idx_r + 3'd1;
              if (next_note.dur == '0) begin
                cue_r <= CUE_NONE;
              end
            end else begin
              cue_cnt_r <= cue_cnt_inc;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // result register: hold until the transfer completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && out_free) begin
      out_data_r.sample  <= dp_acc;
      out_data_r.running <= enabled_r && (music_r || cue_r != CUE_NONE);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  tts_dp u_dp (
    .clk       (clk),
    .ctl       (dp_ctl),
    .phase     (v_phase),
    .freq      (v_freq),
    .pos       (v_pos),
    .dur       (v_dur),
    .phase_new (dp_phase_new),
    .acc       (dp_acc)
  );

`ifndef SYNTH
  a_cue_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cue_r != CUE_NONE) |-> (cue_idx_r < CUE_COUNT[cue_r]))
    else $error("cue note index past the end of its cue");

  a_cue_cnt_in_note: assert property (@(posedge clk) disable iff (!rst_n)
    (cue_r != CUE_NONE) |-> (cue_cnt_r < cur_note.dur))
    else $error("cue position beyond the current note");

  a_mus_pos_in_step: assert property (@(posedge clk) disable iff (!rst_n)
    mus_pos_r < POS_W'(STEP_LEN))
    else $error("music position beyond one step");

  a_phase_wrapped: assert property (@(posedge clk) disable iff (!rst_n)
    (mel_ph_r < PH_W'(SAMPLE_RATE)) && (bass_ph_r < PH_W'(SAMPLE_RATE)) &&
    (cue_ph_r < PH_W'(SAMPLE_RATE)))
    else $error("phase accumulator not wrapped");

  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_ready)
    else $error("input taken again before the result was formed");
`endif

endmodule

[hdl/tts_dp.sv]
// ----------------------------------------------------------------------------
// tts_dp
// Shared voice datapath: phase step, triangle shaping, one multiplier.
// ----------------------------------------------------------------------------
module tts_dp
  import tts_pkg::*;
(
  input  logic                       clk,
  input  dp_ctl_t                    ctl,
  input  logic [PH_W-1:0]            phase,
  input  logic [FREQ_W-1:0]          freq,
  input  logic [POS_W-1:0]           pos,
  input  logic [POS_W-1:0]           dur,
  output logic [PH_W-1:0]            phase_new,
  output logic signed [SAMPLE_W-1:0] acc
);

  logic [PH_W:0]                ph_sum;
  logic [PH_W:0]                ph_wrap;
  logic [PH_W:0]                p2;
  logic [PH_W:0]                mag_wide;
  logic                         neg;
  logic [POS_W-1:0]             rem;
  logic [POS_W-1:0]             env_wide;
  logic [OPND_W-1:0]            opa;
  logic [OPND_W-1:0]            opb;
  logic [PROD_W-1:0]            prod;
  logic [MAG_W-1:0]             scaled;
  logic signed [SAMPLE_W-1:0]   term;

  logic                         neg_r;
  logic [MAG_W-1:0]             tmag_r;
  logic [ENV_W-1:0]             env_r;
  logic [MULR_W-1:0]            mul_r;
  logic signed [SAMPLE_W-1:0]   acc_r;

  // phase step and wrap
  assign ph_sum    = {1'b0, phase} + {{(PH_W + 1 - FREQ_W){1'b0}}, freq};
  assign ph_wrap   = (ph_sum >= (PH_W + 1)'(SAMPLE_RATE)) ?
                     ph_sum - (PH_W + 1)'(SAMPLE_RATE) : ph_sum;
  assign phase_new = ph_wrap[PH_W-1:0];
  assign p2        = {ph_wrap[PH_W-1:0], 1'b0};

  // triangle as sign and magnitude
  always_comb begin
    if (p2 < (PH_W + 1)'(2 * HALF_RATE)) begin
      neg      = p2 < (PH_W + 1)'(HALF_RATE);
      mag_wide = neg ? (PH_W + 1)'(HALF_RATE) - p2 : p2 - (PH_W + 1)'(HALF_RATE);
    end else begin
      neg      = p2 > (PH_W + 1)'(TRI_TOP);
      mag_wide = neg ? p2 - (PH_W + 1)'(TRI_TOP) : (PH_W + 1)'(TRI_TOP) - p2;
    end
  end

  // envelope: shortest of ramp length, distance from start, distance to end
  always_comb begin
    rem      = dur - pos;
    env_wide = POS_W'(ENV_LEN);
    if (pos < env_wide) begin
      env_wide = pos;
    end
    if (rem < env_wide) begin
      env_wide = rem;
    end
  end

  always_comb begin
    unique case (ctl.op)
      DP_MUL_AMP: begin
        opa = OPND_W'(tmag_r);
        opb = OPND_W'(ctl.amp);
      end
      DP_MUL_REC: begin
        opa = OPND_W'(mul_r[24:ENV_SH]);
        opb = OPND_W'(REC_K);
      end
      DP_MUL_ENV: begin
        opa = OPND_W'(mul_r[MULR_W-1:REC_SH]);
        opb = OPND_W'(env_r);
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  assign prod   = opa * opb;
  assign scaled = prod[ENV_SH + MAG_W - 1:ENV_SH];
  assign term   = neg_r ? -$signed({1'b0, scaled}) : $signed({1'b0, scaled});

  always_ff @(posedge clk) begin
    unique case (ctl.op)
      DP_CLEAR: begin
        acc_r <= '0;
      end
      DP_LOAD: begin
        neg_r  <= neg;
        tmag_r <= mag_wide[MAG_W-1:0];
        env_r  <= env_wide[ENV_W-1:0];
      end
      DP_MUL_AMP, DP_MUL_REC: begin
        mul_r <= prod[MULR_W-1:0];
      end
      DP_MUL_ENV: begin
        acc_r <= acc_r + term;
      end
      default: begin
      end
    endcase
  end

  assign acc = acc_r;

endmodule
